// ----- src/b64d_pkg.sv -----
// Shared types and codes for the base64 stream decoder.
package b64d_pkg;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_INVALID    = 2'd1;
  localparam logic [1:0] ST_INCOMPLETE = 2'd2;
  localparam logic [1:0] ST_OVERFLOW   = 2'd3;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic ACT_CHAR = 1'b0;
  localparam logic ACT_END  = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [1:0]  status;
    logic [15:0] total_length;
    logic        last;
  } result_t;

  // Up to three results produced by one request, entries 0 .. count-1 are live.
  typedef struct packed {
    logic [1:0]        count;
    result_t [2:0]     res;
  } push_t;

endpackage

// ----- src/base64_stream_decoder.sv -----
// Top level of the base64 stream decoder: input register, decoder and result queue.
//
// The decoder takes one request per clock on the item channel: a text character
// or the end-of-text marker. A request is registered, decoded in the following
// cycle, and its results (up to three data bytes for a completed group, or one
// status for the end marker) are written into a result queue of 2**FIFO_ADDR_W
// entries that feeds the result channel at one result per cycle while it is not
// stalled. The first result of a request passes through the input register and
// the queue before it can be taken. Sustained throughput is one character per
// cycle, which the queue supports because four characters give at most three
// bytes. The item channel stalls while the queue holds more than 2**FIFO_ADDR_W - 6
// results, which reserves room for the request in the input register and the one
// being accepted; so a result consumer that stalls for long eventually stalls the
// text source. The byte limit is written through the cfg channel, which is always
// ready and should only be written while no text is in flight.
module base64_stream_decoder
  import b64d_pkg::*;
#(
  parameter int FIFO_ADDR_W = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: byte limit of the destination.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data,
  // Item channel.
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        action,
  input  logic [7:0]  character,
  // Result channel.
  output logic        result_valid,
  input  logic        result_stall,
  output logic        result_kind,
  output logic [7:0]  data_byte,
  output logic [1:0]  status,
  output logic [15:0] total_length,
  output logic        last
);

  localparam int DEPTH = 1 << FIFO_ADDR_W;

  logic [15:0]          max_output_bytes;
  logic                 req_valid;
  logic                 req_action;
  logic [7:0]           req_character;
  push_t                push;
  result_t              head;
  logic                 pop;
  logic [FIFO_ADDR_W:0] fifo_count;

  // The register accepts a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_output_bytes <= 16'd1024;
    end else if (cfg_valid && cfg_ready) begin
      max_output_bytes <= cfg_data;
    end
  end

  // Stall when the queue could not absorb the worst case of two requests.
  assign item_stall = (fifo_count > (FIFO_ADDR_W + 1)'(DEPTH - 6));

  // Input register: one request enters per accepted handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= item_valid && !item_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      req_action    <= action;
      req_character <= character;
    end
  end

  b64d_decode u_decode (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_action    (req_action),
    .req_character (req_character),
    .max_bytes     (max_output_bytes),
    .push          (push)
  );

  assign pop = result_valid && !result_stall;

  b64d_result_fifo #(
    .ADDR_W (FIFO_ADDR_W)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .out_valid (result_valid),
    .out_data  (head),
    .count     (fifo_count)
  );

  assign result_kind  = head.kind;
  assign data_byte    = head.data_byte;
  assign status       = head.status;
  assign total_length = head.total_length;
  assign last         = head.last;

endmodule

// ----- src/b64d_decode.sv -----
// Decoder state and the single-pass logic that turns one request into results.
module b64d_decode
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  input  logic        req_action,
  input  logic [7:0]  req_character,
  input  logic [15:0] max_bytes,
  output push_t       push
);

  logic [17:0] group_bits, group_bits_next;
  logic [1:0]  group_count, group_count_next;
  logic [2:0]  pad_count, pad_count_next;
  logic        finished_by_pad, finished_by_pad_next;
  logic [1:0]  error_code, error_code_next;
  logic [15:0] byte_count, byte_count_next;

  // Returns {is_alphabet, sextet}.
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] r;
    r = 7'd0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      r = {1'b1, 6'(ch - 8'h41)};
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      r = {1'b1, 6'(ch - 8'h61 + 8'd26)};
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      r = {1'b1, 6'(ch - 8'h30 + 8'd52)};
    end else if (ch == 8'h2B) begin
      r = {1'b1, 6'd62};
    end else if (ch == 8'h2F) begin
      r = {1'b1, 6'd63};
    end
    return r;
  endfunction

  logic        is_space;
  logic        is_pad;
  logic [6:0]  sx;
  logic [5:0]  sext;
  logic [2:0]  pad_new;
  logic [23:0] triple;
  logic [1:0]  nbytes;
  logic [1:0]  nallow;
  logic [1:0]  nemit;
  logic [16:0] bc_ext, max_ext;

  always_comb begin
    group_bits_next      = group_bits;
    group_count_next     = group_count;
    pad_count_next       = pad_count;
    finished_by_pad_next = finished_by_pad;
    error_code_next      = error_code;
    byte_count_next      = byte_count;
    push                 = '0;

    is_space = (req_character == 8'h20) ||
               (req_character >= 8'h09 && req_character <= 8'h0D);
    is_pad   = (req_character == PAD_CHAR);
    sx       = sextet_of(req_character);
    sext     = is_pad ? 6'd0 : sx[5:0];
    pad_new  = is_pad ? 3'(pad_count + 3'd1) : pad_count;
    triple   = {group_bits, sext};
    nbytes   = (pad_new == 3'd0) ? 2'd3 : ((pad_new == 3'd1) ? 2'd2 : 2'd1);

    // Room left under the limit, counted up to three bytes.
    bc_ext  = {1'b0, byte_count};
    max_ext = {1'b0, max_bytes};
    if (bc_ext >= max_ext) begin
      nallow = 2'd0;
    end else if (bc_ext + 17'd1 >= max_ext) begin
      nallow = 2'd1;
    end else if (bc_ext + 17'd2 >= max_ext) begin
      nallow = 2'd2;
    end else begin
      nallow = 2'd3;
    end
    nemit = (nallow < nbytes) ? nallow : nbytes;

    if (req_valid) begin
      if (req_action == ACT_END) begin
        push.count               = 2'd1;
        push.res[0].kind         = KIND_STATUS;
        push.res[0].status       = (error_code == ST_OK && group_count != 2'd0) ?
                                   ST_INCOMPLETE : error_code;
        push.res[0].total_length = byte_count;
        push.res[0].last         = 1'b1;
        group_bits_next      = '0;
        group_count_next     = '0;
        pad_count_next       = '0;
        finished_by_pad_next = 1'b0;
        error_code_next      = ST_OK;
        byte_count_next      = '0;
      end else if (error_code == ST_OK && !finished_by_pad && !is_space) begin
        if (!is_pad && !sx[6]) begin
          error_code_next = ST_INVALID;
        end else if (group_count != 2'd3) begin
          group_bits_next  = {group_bits[11:0], sext};
          group_count_next = 2'(group_count + 2'd1);
          pad_count_next   = pad_new;
        end else begin
          push.count = nemit;
          push.res[0].data_byte = triple[23:16];
          push.res[1].data_byte = triple[15:8];
          push.res[2].data_byte = triple[7:0];
          for (int k = 0; k < 3; k++) begin
            push.res[k].kind = KIND_DATA;
            push.res[k].last = (2'(k + 1) == nemit);
          end
          if (nallow < nbytes) begin
            error_code_next = ST_OVERFLOW;
          end
          byte_count_next      = byte_count + 16'(nemit);
          finished_by_pad_next = (pad_new != 3'd0);
          group_bits_next      = '0;
          group_count_next     = '0;
          pad_count_next       = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_bits      <= '0;
      group_count     <= '0;
      pad_count       <= '0;
      finished_by_pad <= 1'b0;
      error_code      <= ST_OK;
      byte_count      <= '0;
    end else begin
      group_bits      <= group_bits_next;
      group_count     <= group_count_next;
      pad_count       <= pad_count_next;
      finished_by_pad <= finished_by_pad_next;
      error_code      <= error_code_next;
      byte_count      <= byte_count_next;
    end
  end

endmodule

// ----- src/b64d_result_fifo.sv -----
// Result queue that takes up to three results a cycle and hands out one per pop.
module b64d_result_fifo
  import b64d_pkg::*;
#(
  parameter int ADDR_W = 3
) (
  input  logic            clk,
  input  logic            rst,
  input  push_t           push,
  input  logic            pop,
  output logic            out_valid,
  output result_t         out_data,
  output logic [ADDR_W:0] count
);

  localparam int DEPTH = 1 << ADDR_W;

  result_t [DEPTH-1:0] entries;
  logic [ADDR_W-1:0]   wr_ptr, rd_ptr;

  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push.count) begin
        entries[ADDR_W'(wr_ptr + ADDR_W'(k))] <= push.res[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= ADDR_W'(wr_ptr + ADDR_W'(push.count));
      if (pop) begin
        rd_ptr <= ADDR_W'(rd_ptr + ADDR_W'(1));
      end
      count <= (ADDR_W + 1)'(count + (ADDR_W + 1)'(push.count) -
                             (ADDR_W + 1)'(pop));
    end
  end

endmodule

// ----- tb/base64_checker.sv -----
// Checker for the base64 stream decoder: predicts each result and compares it.
module base64_checker
  import b64d_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic        action,
  input  logic [7:0]  character,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic        result_kind,
  input  logic [7:0]  data_byte,
  input  logic [1:0]  status,
  input  logic [15:0] total_length,
  input  logic        last,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted decoder state.
  logic [15:0] byte_limit;
  logic [17:0] acc_bits;
  int          sextets_held;
  int          pads_seen;
  logic        text_closed;
  logic [1:0]  sticky_err;
  logic [15:0] bytes_out;

  result_t decoded_q [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic clear_text();
    acc_bits = '0;
    sextets_held = 0;
    pads_seen = 0;
    text_closed = 1'b0;
    sticky_err = ST_OK;
    bytes_out = '0;
  endtask

  function automatic int sextet_value(input logic [7:0] ch);
    if (ch >= "A" && ch <= "Z") return ch - "A";
    if (ch >= "a" && ch <= "z") return ch - "a" + 26;
    if (ch >= "0" && ch <= "9") return ch - "0" + 52;
    if (ch == "+") return 62;
    if (ch == "/") return 63;
    return -1;
  endfunction

  // Works out the results that one accepted request causes.
  task automatic decode_request(input logic act, input logic [7:0] ch);
    result_t     r;
    result_t     burst [3];
    logic [5:0]  sx;
    logic [23:0] triple;
    int          v;
    int          nbytes;
    int          n;
    r = '0;
    n = 0;
    if (act == ACT_END) begin
      r.kind = KIND_STATUS;
      r.status = (sticky_err == ST_OK && sextets_held != 0) ? ST_INCOMPLETE : sticky_err;
      r.total_length = bytes_out;
      r.last = 1'b1;
      decoded_q.push_back(r);
      clear_text();
      return;
    end
    if (sticky_err != ST_OK || text_closed) return;
    if (ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D)) return;
    if (ch == PAD_CHAR) begin
      sx = '0;
      pads_seen++;
    end else begin
      v = sextet_value(ch);
      if (v < 0) begin
        sticky_err = ST_INVALID;
        return;
      end
      sx = v[5:0];
    end
    if (sextets_held < 3) begin
      acc_bits = {acc_bits[11:0], sx};
      sextets_held++;
      return;
    end
    triple = {acc_bits, sx};
    nbytes = (pads_seen >= 2) ? 1 : (pads_seen == 1) ? 2 : 3;
    for (int i = 0; i < nbytes; i++) begin
      if (bytes_out >= byte_limit) begin
        sticky_err = ST_OVERFLOW;
        break;
      end
      bytes_out++;
      burst[n] = '0;
      burst[n].kind = KIND_DATA;
      burst[n].data_byte = triple[23 - 8 * i -: 8];
      n++;
    end
    if (n > 0) burst[n - 1].last = 1'b1;
    for (int i = 0; i < n; i++) decoded_q.push_back(burst[i]);
    if (pads_seen > 0) text_closed = 1'b1;
    acc_bits = '0;
    sextets_held = 0;
    pads_seen = 0;
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    result_t want;
    if (decoded_q.size() == 0) begin
      $error("result with no expectation: kind %0d byte 0x%0h status %0d",
             result_kind, data_byte, status);
      fail_count++;
      return;
    end
    want = decoded_q.pop_front();
    compare_field("result_kind", want.kind, result_kind);
    compare_field("data_byte", want.data_byte, data_byte);
    compare_field("status", want.status, status);
    compare_field("total_length", want.total_length, total_length);
    compare_field("last", want.last, last);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      byte_limit = 16'd1024;
      clear_text();
      decoded_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) byte_limit = cfg_data;
      if (result_valid && !result_stall) check_result();
      if (item_valid && !item_stall) decode_request(action, character);
    end
    pending = decoded_q.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// Top of the base64 stream decoder testbench: stimulus, idling, watchdog and verdict.
module tb_top
  import b64d_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // A cycle with no accepted request on any channel counts toward the watchdog.
  // The longest quiet stretch in a correct run is the deliberate result hold-off
  // plus a random gap, well under this limit.
  localparam int QUIET_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 300;
  // Characters that give no result may still be inside the block when the
  // last expected result has arrived, so the drain waits this much longer.
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 100;

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;
  logic        item_valid;
  logic        item_stall;
  logic        action;
  logic [7:0]  character;
  logic        result_valid;
  logic        result_stall;
  logic        result_kind;
  logic [7:0]  data_byte;
  logic [1:0]  status;
  logic [15:0] total_length;
  logic        last;

  int fail_count;
  int pending;

  // Idle rates in percent, changed by the stimulus between phases.
  int send_idle_pct;
  int recv_idle_pct;
  // Set by the stimulus to ask the receiver for one long hold-off.
  logic hold_armed;
  int   hold_left;
  int   items_sent;
  int   quiet_cycles;

  base64_stream_decoder DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .character    (character),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_kind  (result_kind),
    .data_byte    (data_byte),
    .status       (status),
    .total_length (total_length),
    .last         (last)
  );

  base64_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .character    (character),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_kind  (result_kind),
    .data_byte    (data_byte),
    .status       (status),
    .total_length (total_length),
    .last         (last),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver. Outside a hold-off it stalls at the rate of the current phase.
  // A hold-off keeps stall high for a fixed count of cycles so that the result
  // queue fills and the block pushes back on the text source.
  initial begin
    result_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        result_stall <= 1'b1;
        hold_left--;
      end else if (hold_armed) begin
        hold_armed = 1'b0;
        hold_left = HOLD_CYCLES;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // Watchdog. Handshake signals are read at the edge, so they hold the values
  // that the block sees there.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $error("no request accepted for %0d cycles", QUIET_LIMIT);
    $display("** base64_stream_decoder: FAILED **");
    $finish;
  end

  // Offers one request, with random idle cycles first, and returns at the edge
  // where it is accepted. Valid stays high into the next call, so a stream of
  // requests with no idling keeps it high without a glitch.
  task automatic send_item(input logic act, input logic [7:0] ch);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    action <= act;
    character <= ch;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  // The character field is ignored on the end marker, so it carries noise.
  task automatic send_end();
    send_item(ACT_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_chars(input string s);
    for (int i = 0; i < s.len(); i++) send_item(ACT_CHAR, s[i]);
  endtask

  // Waits until every expected result has come, plus the latency margin.
  task automatic wait_drained();
    item_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] alphabet_char(input int v);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    return (v == 62) ? 8'("+") : 8'("/");
  endfunction

  function automatic logic [7:0] blank_char();
    int w;
    w = $urandom_range(0, 5);
    return (w == 5) ? 8'h20 : 8'(8'h09 + w);
  endfunction

  // One random text. Most texts are well formed so that groups complete and
  // the byte limit is reached; the last group may be padded in the usual way,
  // padded in an odd position, made of pads only, or cut short. Whitespace and
  // stray bytes of any code are sprinkled in, and a padded text may carry
  // trailing characters that the block has to ignore.
  task automatic send_text();
    logic [7:0] grp [4];
    int groups;
    int sel;
    int keep;
    groups = $urandom_range(0, 4);
    for (int g = 0; g < groups; g++) begin
      for (int k = 0; k < 4; k++) grp[k] = alphabet_char($urandom_range(0, 63));
      keep = 4;
      if (g == groups - 1) begin
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
          grp[3] = PAD_CHAR;
          if (sel == 0) grp[2] = PAD_CHAR;
        end else if (sel == 3) begin
          grp[$urandom_range(0, 3)] = PAD_CHAR;
        end else if (sel == 4) begin
          for (int k = 0; k < 4; k++) grp[k] = PAD_CHAR;
        end else if (sel == 5) begin
          keep = $urandom_range(1, 3);
        end
      end
      for (int k = 0; k < keep; k++) begin
        if ($urandom_range(0, 9) == 0) send_item(ACT_CHAR, blank_char());
        if ($urandom_range(0, 24) == 0) send_item(ACT_CHAR, 8'($urandom_range(0, 255)));
        send_item(ACT_CHAR, grp[k]);
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) send_item(ACT_CHAR, alphabet_char($urandom_range(0, 63)));
    end
    send_end();
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    item_valid = 1'b0;
    action = ACT_CHAR;
    character = '0;
    hold_armed = 1'b0;
    items_sent = 0;
    send_idle_pct = 20;
    recv_idle_pct = 81;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, at the reset limit of 1024 bytes. The first text runs the
    // alphabet's extremes with whitespace between the first two groups and ends with a
    // group that has two pads, one of them in the middle, and a character
    // after it that must be ignored.
    send_chars("AZaz");
    send_item(ACT_CHAR, 8'h09);
    send_item(ACT_CHAR, 8'h20);
    send_chars("09+/");
    send_chars("A=A=B");
    send_end();
    // A group with one pad gives two bytes.
    send_chars("TWE=");
    send_end();
    // An invalid character is sticky and gives the invalid status.
    send_chars("Q");
    send_item(ACT_CHAR, 8'hFF);
    send_end();
    // An unfinished group, then an empty text.
    send_chars("Q");
    send_end();
    send_end();
    wait_drained();

    // A limit of zero turns the first byte into an overflow.
    write_limit(16'd0);
    send_chars("QUJD");
    send_end();
    wait_drained();

    // Random part in three idling phases, each with its own byte limit.
    for (int phase = 0; phase < 3; phase++) begin
      int phase_end;
      case (phase)
        0: begin
          send_idle_pct = 20;
          recv_idle_pct = 81;
          write_limit(16'hFFFF);
        end
        1: begin
          send_idle_pct = 81;
          recv_idle_pct = 20;
          write_limit(16'($urandom_range(2, 12)));
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          write_limit(16'($urandom_range(13, 65535)));
          hold_armed = 1'b1;
        end
      endcase
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) send_text();
      wait_drained();
    end

    if (pending != 0) $error("%0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0)
      $display("** base64_stream_decoder: PASSED **");
    else
      $display("** base64_stream_decoder: FAILED **");
    $finish;
  end

endmodule
